>>> design/c_comment_stripper_unit_assert.svh
// assertion helpers shared by the stripper modules
// clk and rst are taken from the scope of the module that uses them
`ifndef C_COMMENT_STRIPPER_UNIT_ASSERT_SVH
`define C_COMMENT_STRIPPER_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define CCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds at the same edge as the antecedent
`define CCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds at the edge after the antecedent
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ccs_pkg.sv
`timescale 1ns / 1ps
package ccs_pkg;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // newlines owed before text never exceed this
  localparam int MAX_BLANK_RUN = 2;

  // fixed part of one emit command; the hold span travels beside it
  typedef struct packed {
    logic [1:0] nl;    // owed newlines, sent first
    logic       b0_v;  // first literal byte after the held span
    logic [7:0] b0;
    logic       b1_v;  // second literal byte
    logic [7:0] b1;
    logic       env;   // closing newline at end of text
    logic       done;  // command belongs to the end of text
  } ccs_cmd_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};
  endfunction

endpackage

>>> design/ccs_ram.sv
`timescale 1ns / 1ps
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ccs_scan.sv
`timescale 1ns / 1ps
`include "c_comment_stripper_unit_assert.svh"
module ccs_scan import ccs_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic                                 cfg_wdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,
  input  logic                                 s_tlast,
  input  logic [$clog2(4*HOLD_DEPTH):0]        rel_ptr,
  output logic                                 ram_we,
  output logic [$clog2(4*HOLD_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                           ram_wdata,
  output logic                                 cmd_valid,
  output ccs_cmd_t                             cmd,
  output logic [$clog2(4*HOLD_DEPTH):0]        cmd_hstart,
  output logic [$clog2(HOLD_DEPTH+1)-1:0]      cmd_hlen,
  input  logic                                 cmd_take
);

  localparam int RING_DEPTH = 2 ** $clog2(4 * HOLD_DEPTH);
  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  typedef enum logic [2:0] {M_NORMAL, M_SLASH, M_LINE, M_BLOCK, M_STAR} mode_t;

  typedef struct packed {
    logic [7:0]    lk;
    logic [CW-1:0] hc;
    logic [1:0]    br;
    logic          lht;
    logic [PW:0]   base;
  } sst_t;

  typedef struct packed {
    logic [1:0]    nl;
    logic [PW:0]   hstart;
    logic [CW-1:0] hlen;
    logic          b0_v;
    logic [7:0]    b0;
    logic          b1_v;
    logic [7:0]    b1;
    logic          we;
    logic [PW:0]   wptr;
    logic [7:0]    wdata;
  } em_t;

  typedef struct packed {
    sst_t s;
    em_t  e;
  } kr_t;

  mode_t         mode, mode_next;
  logic [7:0]    lk;
  logic [CW-1:0] hc;
  logic [1:0]    br;
  logic          lht;
  logic [PW:0]   base;
  logic          ended, ended_next;
  logic          remove_blank;

  kr_t           k;
  logic          eot, env, has_out, accept, ring_ok;
  logic [PW:0]   occ;
  logic [7:0]    c;

  // owed newlines and the held span go out ahead of the first text
  function automatic kr_t start_text(input kr_t k_in, input logic rb);
    kr_t r;
    r = k_in;
    if (!r.s.lht) begin
      r.e.nl  = (rb && r.s.br > 2'd1) ? 2'd1 : r.s.br;
      r.s.br  = 2'd0;
      r.s.lht = 1'b1;
    end
    if (r.s.hc != '0) begin
      r.e.hstart = r.s.base;
      r.e.hlen   = r.s.hc;
      r.s.base   = r.s.base + (PW+1)'(r.s.hc);
      r.s.hc     = '0;
    end
    return r;
  endfunction

  function automatic kr_t keep(input kr_t k_in, input logic [7:0] ch, input logic rb);
    kr_t r;
    r = k_in;
    r.s.lk = ch;
    if (ch == CH_NL) begin
      r.s.hc = '0;
      if (r.s.lht) begin
        r.s.br  = 2'd1;
        r.s.lht = 1'b0;
      end else if (r.s.br != 2'd0 && r.s.br < 2'(MAX_BLANK_RUN)) begin
        r.s.br = r.s.br + 2'd1;
      end
    end else if (is_ws(ch)) begin
      r.e.we    = 1'b1;
      r.e.wptr  = r.s.base + (PW+1)'(r.s.hc);
      r.e.wdata = ch;
      r.s.hc    = r.s.hc + CW'(1);
      if (r.s.hc >= CW'(HOLD_DEPTH)) begin
        r = start_text(r, rb);
      end
    end else begin
      r = start_text(r, rb);
      if (!r.e.b0_v) begin
        r.e.b0_v = 1'b1;
        r.e.b0   = ch;
      end else begin
        r.e.b1_v = 1'b1;
        r.e.b1   = ch;
      end
    end
    return r;
  endfunction

  assign c = s_tdata;

  // room for a full hold span after the newest flushed span
  assign occ     = base - rel_ptr;
  assign ring_ok = occ <= (PW+1)'(RING_DEPTH - 2 * HOLD_DEPTH);

  assign s_tready = ring_ok && (!cmd_valid || cmd_take);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    k.s        = '{lk: lk, hc: hc, br: br, lht: lht, base: base};
    k.e        = '0;
    mode_next  = mode;
    ended_next = ended;
    env        = 1'b0;
    eot        = s_tlast || (c == CH_NUL);
    if (!ended) begin
      if (c != CH_NUL) begin
        case (mode)
          M_SLASH: begin
            if (c == CH_SLASH && lk != CH_BSL) begin
              mode_next = M_LINE;
            end else if (c == CH_STAR) begin
              mode_next = M_BLOCK;
            end else if (c == CH_SLASH) begin
              k = keep(k, CH_SLASH, remove_blank);
            end else begin
              mode_next = M_NORMAL;
              k = keep(k, CH_SLASH, remove_blank);
              k = keep(k, c, remove_blank);
            end
          end
          M_LINE: begin
            if (c == CH_NL) begin
              mode_next = M_NORMAL;
              k = keep(k, c, remove_blank);
            end
          end
          M_BLOCK: begin
            if (c == CH_STAR) begin
              mode_next = M_STAR;
            end
          end
          M_STAR: begin
            if (c == CH_SLASH) begin
              mode_next = M_NORMAL;
            end else if (c != CH_STAR) begin
              mode_next = M_BLOCK;
            end
          end
          default: begin
            if (c == CH_SLASH) begin
              mode_next = M_SLASH;
            end else begin
              mode_next = M_NORMAL;
              k = keep(k, c, remove_blank);
            end
          end
        endcase
      end
      if (eot) begin
        if (mode_next == M_SLASH) begin
          k = keep(k, CH_SLASH, remove_blank);
        end
        env        = k.s.lht || (k.s.br != 2'd0);
        mode_next  = M_NORMAL;
        k.s.hc     = '0;
        k.s.br     = 2'd0;
        k.s.lht    = 1'b0;
        ended_next = 1'b1;
      end
    end
    has_out = (k.e.hlen != '0) || (k.e.nl != 2'd0) || k.e.b0_v || k.e.b1_v || env;
  end

  assign ram_we    = accept && k.e.we;
  assign ram_waddr = k.e.wptr[PW-1:0];
  assign ram_wdata = k.e.wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_NORMAL;
      lk           <= 8'd0;
      hc           <= '0;
      br           <= 2'd0;
      lht          <= 1'b0;
      base         <= '0;
      ended        <= 1'b0;
      remove_blank <= 1'b0;
      cmd_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        remove_blank <= cfg_wdata;
      end
      if (accept) begin
        mode  <= mode_next;
        lk    <= k.s.lk;
        hc    <= k.s.hc;
        br    <= k.s.br;
        lht   <= k.s.lht;
        base  <= k.s.base;
        ended <= ended_next;
      end
      if (accept && has_out) begin
        cmd_valid  <= 1'b1;
        cmd        <= '{nl: k.e.nl, b0_v: k.e.b0_v, b0: k.e.b0, b1_v: k.e.b1_v,
                        b1: k.e.b1, env: env, done: eot};
        cmd_hstart <= k.e.hstart;
        cmd_hlen   <= k.e.hlen;
      end else if (cmd_take) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  `CCS_ASSERT_ALWAYS(a_hold_bound, hc < CW'(HOLD_DEPTH), "hold count reached its depth")
  `CCS_ASSERT_ALWAYS(a_ring_bound, occ <= (PW+1)'(RING_DEPTH), "hold ring overrun")
  `CCS_ASSERT_NEXT(a_end_sticky, ended, ended, "end of text cleared without reset")
  `CCS_ASSERT_IMPL(a_quiet_after_end, ended && accept, !has_out, "output after end of text")

endmodule

>>> design/ccs_emit.sv
`timescale 1ns / 1ps
`include "c_comment_stripper_unit_assert.svh"
module ccs_emit import ccs_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  ccs_cmd_t                             cmd,
  input  logic [$clog2(4*HOLD_DEPTH):0]        cmd_hstart,
  input  logic [$clog2(HOLD_DEPTH+1)-1:0]      cmd_hlen,
  output logic                                 cmd_take,
  output logic                                 ram_re,
  output logic [$clog2(4*HOLD_DEPTH)-1:0]      ram_raddr,
  input  logic [7:0]                           ram_rdata,
  output logic [$clog2(4*HOLD_DEPTH):0]        rel_ptr,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,
  output logic                                 m_tlast,
  output logic                                 m_tuser
);

  localparam int PW = $clog2(2 ** $clog2(4 * HOLD_DEPTH));
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  // command being expanded
  logic          cur_v;
  logic [1:0]    nl_rem, nl_a;
  logic [CW-1:0] h_rem, h_a;
  logic [PW:0]   h_addr, addr_a;
  logic          b0_v, b0_a, b1_v, b1_a, e_v, e_a;
  logic [7:0]    b0, b1;
  logic          cur_done;

  // output word
  logic          o_v, o_is_h, o_last, o_done;
  logic [7:0]    o_byte;

  logic          sel_h, is_last, advance;
  logic [7:0]    sel_byte;

  // order: owed newlines, held span, literal bytes, closing newline
  always_comb begin
    nl_a     = nl_rem;
    h_a      = h_rem;
    addr_a   = h_addr;
    b0_a     = b0_v;
    b1_a     = b1_v;
    e_a      = e_v;
    sel_h    = 1'b0;
    sel_byte = CH_NL;
    if (nl_rem != 2'd0) begin
      nl_a = nl_rem - 2'd1;
    end else if (h_rem != '0) begin
      sel_h  = 1'b1;
      h_a    = h_rem - CW'(1);
      addr_a = h_addr + (PW+1)'(1);
    end else if (b0_v) begin
      sel_byte = b0;
      b0_a     = 1'b0;
    end else if (b1_v) begin
      sel_byte = b1;
      b1_a     = 1'b0;
    end else begin
      e_a = 1'b0;
    end
    is_last = (nl_a == 2'd0) && (h_a == '0) && !b0_a && !b1_a && !e_a;
  end

  assign advance   = cur_v && (!o_v || m_tready);
  assign cmd_take  = cmd_valid && (!cur_v || (advance && is_last));
  assign ram_re    = advance && sel_h;
  assign ram_raddr = h_addr[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v   <= 1'b0;
      o_v     <= 1'b0;
      rel_ptr <= '0;
    end else begin
      if (advance) begin
        o_v    <= 1'b1;
        o_is_h <= sel_h;
        o_byte <= sel_byte;
        o_last <= is_last;
        o_done <= is_last && cur_done;
      end else if (m_tready) begin
        o_v <= 1'b0;
      end
      if (ram_re) begin
        rel_ptr <= addr_a;
      end
      if (cmd_take) begin
        cur_v    <= 1'b1;
        nl_rem   <= cmd.nl;
        h_rem    <= cmd_hlen;
        h_addr   <= cmd_hstart;
        b0_v     <= cmd.b0_v;
        b0       <= cmd.b0;
        b1_v     <= cmd.b1_v;
        b1       <= cmd.b1;
        e_v      <= cmd.env;
        cur_done <= cmd.done;
      end else if (advance) begin
        nl_rem <= nl_a;
        h_rem  <= h_a;
        h_addr <= addr_a;
        b0_v   <= b0_a;
        b1_v   <= b1_a;
        e_v    <= e_a;
        if (is_last) begin
          cur_v <= 1'b0;
        end
      end
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = o_is_h ? ram_rdata : o_byte;
  assign m_tlast  = o_last;
  assign m_tuser  = o_done;

  `CCS_ASSERT_NEXT(a_held_read_stable, o_v && o_is_h && !m_tready, $stable(ram_rdata),
    "held byte changed under a stalled word")
  `CCS_ASSERT_IMPL(a_done_is_last, o_v && o_done, o_last, "text end word not last of its run")

endmodule

>>> design/c_comment_stripper_unit.sv
// c comment stripper: removes // and /* */ comments from a byte stream,
// drops trailing whitespace, caps or removes blank lines.
// input channel s_*: one source byte per word; s_tlast marks the final
// byte of the text, a NUL byte also ends it.
// output channel m_*: one stripped byte per word; m_tlast closes the
// words caused by one input word, m_tuser flags the last word of the text.
// cfg_wen/cfg_wdata write remove_blank (1 drops all blank lines); write it
// only while the block is idle.
// path: the first word of an input is registered in the command stage,
// then in the expander's command register, then in the output register.
// throughput: the output sends one word per cycle while m_tready is high; an
// input word is taken every cycle while the command stage drains, so input
// words that give at most one result each flow at one per cycle. a word that
// releases held whitespace keeps the expander busy until all its result
// words are out, which sets the input rate over such bursts.
// reset: synchronous, clears scan state and both channels; the hold ring
// needs no clearing pass. a stalled receiver holds the output word and,
// once the command stage is full, drops s_tready.
`timescale 1ns / 1ps
module c_comment_stripper_unit import ccs_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,  // remove_blank
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] text_byte
  input  logic       s_tlast,    // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic       m_tlast,    // last_of_run
  output logic       m_tuser     // text_done
);

  // hold ring: each flushed span stays until the expander has read it,
  // while the scanner keeps filling the next span behind it
  localparam int RING_DEPTH = 2 ** $clog2(4 * HOLD_DEPTH);
  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  logic          ram_we, ram_re;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [PW:0]   rel_ptr;

  // one command per input word that gives results
  logic          cmd_valid, cmd_take;
  ccs_cmd_t      cmd;
  logic [PW:0]   cmd_hstart;
  logic [CW-1:0] cmd_hlen;

  // scanner: comment state machine, line and blank tracking, hold writes
  ccs_scan #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .rel_ptr    (rel_ptr),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_hstart (cmd_hstart),
    .cmd_hlen   (cmd_hlen),
    .cmd_take   (cmd_take)
  );

  // held whitespace store, one write port and one registered read port
  ccs_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_hold (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // expander: turns each command into output words, one per cycle while m_tready is high
  ccs_emit #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_hstart (cmd_hstart),
    .cmd_hlen   (cmd_hlen),
    .cmd_take   (cmd_take),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .rel_ptr    (rel_ptr),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
